// ===== src/wsdf_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
`timescale 1ns / 1ps

package wsdf_pkg;

	// Default width of the frame length counter
	localparam int LENGTH_WIDTH_DEF = 64;

	// Entries in the result queue
	localparam int RES_FIFO_DEPTH = 4;

	// Header field codes
	localparam logic [3:0] OPC_TEXT    = 4'h1;
	localparam logic [6:0] LEN7_EXT16  = 7'd126;
	localparam logic [6:0] LEN7_EXT64  = 7'd127;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;

	typedef enum logic [2:0] {
		PH_BYTE0,
		PH_BYTE1,
		PH_EXT,
		PH_PAYLOAD,
		PH_TRAIL
	} parse_phase_t;

	typedef enum logic [1:0] {
		ST_COMPLETE,
		ST_NOT_TEXT,
		ST_HDR_SHORT,
		ST_PAY_SHORT
	} frame_status_t;

	typedef struct packed {
		logic [7:0]    payload_byte;
		logic          is_status;
		frame_status_t frame_status;
		logic          last;
	} result_t;

	// Write request into the result queue: up to two words per cycle
	typedef struct packed {
		logic    valid0;
		logic    valid1;
		result_t word0;
		result_t word1;
	} push_t;

endpackage

// ===== src/wsdf_in_if.sv =====
// Byte stream channel into the deframer.
`timescale 1ns / 1ps

interface wsdf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_buffer;

	modport source(output valid, output data_byte, output end_of_buffer, input ready);
	modport sink(input valid, input data_byte, input end_of_buffer, output ready);
endinterface

// ===== src/wsdf_out_if.sv =====
// Result channel out of the deframer.
`timescale 1ns / 1ps

interface wsdf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       is_status;
	logic [1:0] frame_status;
	logic       last;

	modport source(output valid, output payload_byte, output is_status,
		output frame_status, output last, input ready);
	modport sink(input valid, input payload_byte, input is_status,
		input frame_status, input last, output ready);
endinterface

// ===== src/wsdf_res_fifo.sv =====
// Result queue: takes up to two words per cycle, hands out one while the reader is ready.
`timescale 1ns / 1ps

module wsdf_res_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  wsdf_pkg::push_t push,
	output logic           room2,
	wsdf_out_if.source     result
);
	localparam int DEPTH = wsdf_pkg::RES_FIFO_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	wsdf_pkg::result_t mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic [PTR_W-1:0]  wr_ptr_nx1;
	logic [PTR_W-1:0]  wr_ptr_nx2;
	logic [CNT_W-1:0]  push_n;
	logic              pop;
	wsdf_pkg::result_t head;

	// Space check for the worst case of two words
	assign room2 = (count_q <= CNT_W'(DEPTH - 2));

	assign wr_ptr_nx1 = PTR_W'(wr_ptr_q + 1'b1);
	assign wr_ptr_nx2 = PTR_W'(wr_ptr_q + 2'd2);
	assign push_n     = CNT_W'(push.valid0) + CNT_W'(push.valid1);
	assign pop        = result.valid && result.ready;

	// Drive the head word
	assign head                = mem_q[rd_ptr_q];
	assign result.valid        = (count_q != '0);
	assign result.payload_byte = head.payload_byte;
	assign result.is_status    = head.is_status;
	assign result.frame_status = head.frame_status;
	assign result.last         = head.last;

	// Store incoming words
	always_ff @(posedge clk) begin
		if (push.valid0) begin
			mem_q[wr_ptr_q] <= push.word0;
		end
		if (push.valid1) begin
			mem_q[wr_ptr_nx1] <= push.word1;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid1) begin
				wr_ptr_q <= wr_ptr_nx2;
			end else if (push.valid0) begin
				wr_ptr_q <= wr_ptr_nx1;
			end
			if (pop) begin
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			end
			count_q <= CNT_W'(count_q + push_n - CNT_W'(pop));
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("result queue fill count out of range");

	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid1 |-> push.valid0)
		else $error("second word pushed without first");

	a_push_two_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push.valid1 && !pop) |=> count_q == CNT_W'($past(count_q) + 2'd2))
		else $error("fill count missed a double push");

endmodule

// ===== src/websocket_frame_deframer_core.sv =====
// An accepted byte is held in the input stage and pushed into the result queue once the queue
// has room for two words. One byte per cycle while that room lasts; a final byte that is also
// payload makes two words, and the four-entry result queue drains one word per cycle while
// the reader is ready. Input is taken while the input stage is empty or the queue has room.
// Reset (arst_n low) clears the input stage, the parse state and the result queue.
`timescale 1ns / 1ps

module websocket_frame_deframer_core #(
	parameter int LENGTH_WIDTH = wsdf_pkg::LENGTH_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	wsdf_in_if.sink    data,
	wsdf_out_if.source result
);
	localparam int W = LENGTH_WIDTH;

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eob_s1;

	// Parse state
	wsdf_pkg::parse_phase_t phase_q, phase_d;
	logic [3:0]             ext_q, ext_d;
	logic [W-1:0]           len_q, len_d;
	logic                   ovf_q, ovf_d;
	logic                   not_text_q, not_text_d;

	logic                   room2;
	logic                   advance;
	wsdf_pkg::push_t        push;
	wsdf_pkg::result_t      pay_word;
	wsdf_pkg::result_t      stat_word;
	logic                   pay_out;
	wsdf_pkg::frame_status_t stat;
	logic [W-1:0]           shifted;
	logic                   ovf_n;
	logic [W-1:0]           start_len;

	assign advance    = valid_s1 && room2;
	assign data.ready = !valid_s1 || room2;

	// Hold the accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data.valid && data.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (data.valid && data.ready) begin
			byte_s1 <= data.data_byte;
			eob_s1  <= data.end_of_buffer;
		end
	end

	// Extended length accumulation; saturate when bits fall off the top
	assign shifted   = {len_q[W-9:0], byte_s1};
	assign ovf_n     = ovf_q || (len_q[W-1 -: 8] != 8'd0);
	assign start_len = ovf_n ? {W{1'b1}} : shifted;

	// Next parse state
	always_comb begin
		phase_d    = phase_q;
		ext_d      = ext_q;
		len_d      = len_q;
		ovf_d      = ovf_q;
		not_text_d = not_text_q;
		pay_out    = 1'b0;
		case (phase_q)
			wsdf_pkg::PH_BYTE0: begin
				not_text_d = (byte_s1[3:0] != wsdf_pkg::OPC_TEXT);
				phase_d    = wsdf_pkg::PH_BYTE1;
			end
			wsdf_pkg::PH_BYTE1: begin
				if (not_text_q) begin
					phase_d = wsdf_pkg::PH_TRAIL;
				end else begin
					len_d = '0;
					ovf_d = 1'b0;
					if (byte_s1[6:0] == wsdf_pkg::LEN7_EXT16) begin
						ext_d   = wsdf_pkg::EXT16_BYTES;
						phase_d = wsdf_pkg::PH_EXT;
					end else if (byte_s1[6:0] == wsdf_pkg::LEN7_EXT64) begin
						ext_d   = wsdf_pkg::EXT64_BYTES;
						phase_d = wsdf_pkg::PH_EXT;
					end else begin
						len_d   = W'(byte_s1[6:0]);
						phase_d = (byte_s1[6:0] != 7'd0) ? wsdf_pkg::PH_PAYLOAD
							: wsdf_pkg::PH_TRAIL;
					end
				end
			end
			wsdf_pkg::PH_EXT: begin
				ext_d = 4'(ext_q - 1'b1);
				if (ext_q == 4'd1) begin
					len_d   = start_len;
					ovf_d   = 1'b0;
					phase_d = (start_len != '0) ? wsdf_pkg::PH_PAYLOAD
						: wsdf_pkg::PH_TRAIL;
				end else begin
					len_d = shifted;
					ovf_d = ovf_n;
				end
			end
			wsdf_pkg::PH_PAYLOAD: begin
				pay_out = 1'b1;
				len_d   = W'(len_q - 1'b1);
				if (len_q == W'(1)) begin
					phase_d = wsdf_pkg::PH_TRAIL;
				end
			end
			default: begin
			end
		endcase
	end

	// End-of-buffer status from the updated state
	always_comb begin
		if (phase_d inside {wsdf_pkg::PH_BYTE0, wsdf_pkg::PH_BYTE1}) begin
			stat = wsdf_pkg::ST_HDR_SHORT;
		end else if (not_text_d) begin
			stat = wsdf_pkg::ST_NOT_TEXT;
		end else if (phase_d == wsdf_pkg::PH_EXT) begin
			stat = wsdf_pkg::ST_HDR_SHORT;
		end else if (phase_d == wsdf_pkg::PH_PAYLOAD) begin
			stat = wsdf_pkg::ST_PAY_SHORT;
		end else begin
			stat = wsdf_pkg::ST_COMPLETE;
		end
	end

	// Build the result words for this byte
	always_comb begin
		pay_word.payload_byte = byte_s1;
		pay_word.is_status    = 1'b0;
		pay_word.frame_status = wsdf_pkg::ST_COMPLETE;
		pay_word.last         = 1'b0;

		stat_word.payload_byte = 8'd0;
		stat_word.is_status    = 1'b1;
		stat_word.frame_status = stat;
		stat_word.last         = 1'b1;

		push.valid0 = advance && (pay_out || eob_s1);
		push.valid1 = advance && pay_out && eob_s1;
		push.word0  = pay_out ? pay_word : stat_word;
		push.word1  = stat_word;
	end

	// Update parse state; drop everything at the end of the buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= wsdf_pkg::PH_BYTE0;
			ext_q      <= '0;
			len_q      <= '0;
			ovf_q      <= 1'b0;
			not_text_q <= 1'b0;
		end else if (advance) begin
			if (eob_s1) begin
				phase_q    <= wsdf_pkg::PH_BYTE0;
				ext_q      <= '0;
				len_q      <= '0;
				ovf_q      <= 1'b0;
				not_text_q <= 1'b0;
			end else begin
				phase_q    <= phase_d;
				ext_q      <= ext_d;
				len_q      <= len_d;
				ovf_q      <= ovf_d;
				not_text_q <= not_text_d;
			end
		end
	end

	wsdf_res_fifo u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room2  (room2),
		.result (result)
	);

	a_payload_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == wsdf_pkg::PH_PAYLOAD |-> len_q != '0)
		else $error("payload phase with zero bytes left");

	a_ext_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == wsdf_pkg::PH_EXT |-> (ext_q != 4'd0 && ext_q <= wsdf_pkg::EXT64_BYTES))
		else $error("extended length count out of range");

	a_not_text_skip: assert property (@(posedge clk) disable iff (!arst_n)
		not_text_q |-> (phase_q != wsdf_pkg::PH_EXT && phase_q != wsdf_pkg::PH_PAYLOAD))
		else $error("non-text frame entered length or payload phase");

	a_eob_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && eob_s1) |=> (phase_q == wsdf_pkg::PH_BYTE0 && !not_text_q))
		else $error("parser did not restart after end of buffer");

endmodule
